// ----- rtl/core/apt_pkg.sv -----
// Types and constants shared by the periodic timer modules.
`default_nettype none

package apt_pkg;

  // Transaction kinds on the input channel
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  // Register map byte offsets
  localparam logic [7:0] OFS_LOAD     = 8'h00;
  localparam logic [7:0] OFS_VALUE    = 8'h04;
  localparam logic [7:0] OFS_CONTROL  = 8'h08;
  localparam logic [7:0] OFS_IRQ_CLR  = 8'h0c;
  localparam logic [7:0] OFS_RAW_IRQ  = 8'h10;
  localparam logic [7:0] OFS_MSK_IRQ  = 8'h14;
  localparam logic [7:0] OFS_BG_LOAD  = 8'h18;
  localparam logic [7:0] OFS_PREDIV   = 8'h1c;
  localparam logic [7:0] OFS_FREE_CNT = 8'h20;

  // Register constants
  localparam logic [31:0] ID_WORD        = 32'h544d_5241;
  localparam logic [31:0] CTL_WRITE_MASK = 32'h00ff_03ae;
  localparam logic [31:0] CTL_RESET      = 32'h003e_0000;
  localparam logic [15:0] PREDIV_RESET   = 16'h007d;

  // Control register bit positions
  localparam int unsigned CtlFreeEnBit = 9;
  localparam int unsigned CtlTmrEnBit  = 7;
  localparam int unsigned CtlIrqEnBit  = 5;
  localparam int unsigned CtlPsLsb     = 2;
  localparam int unsigned CtlFpsLsb    = 16;

  // Prescale codes and terminal counts
  localparam logic [1:0] PS_DIV16  = 2'd1;
  localparam logic [1:0] PS_DIV256 = 2'd2;
  localparam logic [7:0] PS_LAST16  = 8'd15;
  localparam logic [7:0] PS_LAST256 = 8'd255;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic        apb_tick;
    logic        sys_tick;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        bad_access;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/core/apt_core.sv -----
// Timer register file, counters and per-transaction next-state logic.
`default_nettype none

module apt_core #(
  parameter int unsigned COUNTER_WIDTH = 32,
  parameter int unsigned PREDIV_WIDTH  = 10
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire apt_pkg::in_t in_i,
  output apt_pkg::out_t     res_o
);

  logic [COUNTER_WIDTH-1:0] reload_q, reload_d;
  logic [COUNTER_WIDTH-1:0] down_q, down_d;
  logic [31:0]              ctl_q, ctl_d;
  logic                     raw_q, raw_d;
  logic [PREDIV_WIDTH-1:0]  prediv_q, prediv_d;
  logic [31:0]              free_q, free_d;
  logic [PREDIV_WIDTH-1:0]  pdc_q, pdc_d;
  logic [7:0]               psc_q, psc_d;
  logic [7:0]               fpsc_q, fpsc_d;

  logic [31:0] rdata;
  logic        bad;
  logic [7:0]  ps_last;
  logic [1:0]  ps_code;

  // Select the prescaler terminal count
  always_comb begin
    ps_code = ctl_q[apt_pkg::CtlPsLsb +: 2];
    case (ps_code)
      apt_pkg::PS_DIV16:  ps_last = apt_pkg::PS_LAST16;
      apt_pkg::PS_DIV256: ps_last = apt_pkg::PS_LAST256;
      default:            ps_last = 8'd0;
    endcase
  end

  // Compute next state and result for the presented transaction
  always_comb begin
    reload_d = reload_q;
    down_d   = down_q;
    ctl_d    = ctl_q;
    raw_d    = raw_q;
    prediv_d = prediv_q;
    free_d   = free_q;
    pdc_d    = pdc_q;
    psc_d    = psc_q;
    fpsc_d   = fpsc_q;
    rdata    = 32'd0;
    bad      = 1'b0;

    case (in_i.opcode)
      apt_pkg::OP_READ: begin
        case (in_i.offset)
          apt_pkg::OFS_LOAD:     rdata = 32'(reload_q);
          apt_pkg::OFS_VALUE:    rdata = 32'(down_q);
          apt_pkg::OFS_CONTROL:  rdata = ctl_q;
          apt_pkg::OFS_IRQ_CLR:  rdata = apt_pkg::ID_WORD;
          apt_pkg::OFS_RAW_IRQ:  rdata = 32'(raw_q);
          apt_pkg::OFS_MSK_IRQ:  rdata = 32'(raw_q & ctl_q[apt_pkg::CtlIrqEnBit]);
          apt_pkg::OFS_BG_LOAD:  rdata = 32'(reload_q);
          apt_pkg::OFS_PREDIV:   rdata = 32'(prediv_q);
          apt_pkg::OFS_FREE_CNT: rdata = free_q;
          default:               bad   = 1'b1;
        endcase
      end
      apt_pkg::OP_WRITE: begin
        case (in_i.offset)
          apt_pkg::OFS_LOAD: begin
            reload_d = in_i.write_data[COUNTER_WIDTH-1:0];
            down_d   = in_i.write_data[COUNTER_WIDTH-1:0];
          end
          apt_pkg::OFS_CONTROL: begin
            ctl_d  = in_i.write_data & apt_pkg::CTL_WRITE_MASK;
            pdc_d  = '0;
            psc_d  = 8'd0;
            fpsc_d = 8'd0;
            if (in_i.write_data[apt_pkg::CtlTmrEnBit]) begin
              down_d = reload_q;
            end
            if (in_i.write_data[apt_pkg::CtlFreeEnBit]) begin
              free_d = free_q + 32'd1;
            end
          end
          apt_pkg::OFS_IRQ_CLR: raw_d    = 1'b0;
          apt_pkg::OFS_BG_LOAD: reload_d = in_i.write_data[COUNTER_WIDTH-1:0];
          apt_pkg::OFS_PREDIV:  prediv_d = in_i.write_data[PREDIV_WIDTH-1:0];
          apt_pkg::OFS_VALUE, apt_pkg::OFS_RAW_IRQ,
          apt_pkg::OFS_MSK_IRQ, apt_pkg::OFS_FREE_CNT: ;
          default: bad = 1'b1;
        endcase
      end
      apt_pkg::OP_TICK: begin
        // Advance the main chain: predivider, prescaler, down counter
        if (in_i.apb_tick && ctl_q[apt_pkg::CtlTmrEnBit]) begin
          if (pdc_q >= prediv_q) begin
            pdc_d = '0;
            if (psc_q >= ps_last) begin
              psc_d = 8'd0;
              if (down_q <= COUNTER_WIDTH'(1)) begin
                down_d = reload_q;
                raw_d  = 1'b1;
              end else begin
                down_d = down_q - COUNTER_WIDTH'(1);
              end
            end else begin
              psc_d = psc_q + 8'd1;
            end
          end else begin
            pdc_d = pdc_q + PREDIV_WIDTH'(1);
          end
        end
        // Advance the free-running counter through its prescaler
        if (in_i.sys_tick && ctl_q[apt_pkg::CtlFreeEnBit]) begin
          if (fpsc_q >= ctl_q[apt_pkg::CtlFpsLsb +: 8]) begin
            fpsc_d = 8'd0;
            free_d = free_q + 32'd1;
          end else begin
            fpsc_d = fpsc_q + 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.read_data  = rdata;
  assign res_o.irq_out    = raw_d & ctl_d[apt_pkg::CtlIrqEnBit];
  assign res_o.bad_access = bad;

  // Commit state on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      down_q   <= '0;
      ctl_q    <= apt_pkg::CTL_RESET;
      raw_q    <= 1'b0;
      prediv_q <= PREDIV_WIDTH'(apt_pkg::PREDIV_RESET);
      free_q   <= 32'd0;
      pdc_q    <= '0;
      psc_q    <= 8'd0;
      fpsc_q   <= 8'd0;
    end else if (en_i) begin
      reload_q <= reload_d;
      down_q   <= down_d;
      ctl_q    <= ctl_d;
      raw_q    <= raw_d;
      prediv_q <= prediv_d;
      free_q   <= free_d;
      pdc_q    <= pdc_d;
      psc_q    <= psc_d;
      fpsc_q   <= fpsc_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/arm_style_periodic_timer_unit.sv -----
// Top level of the periodic timer with free-running counter.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one transaction:
// a bus read, a bus write, or a clock tick with peripheral and system tick
// flags. Each transaction yields exactly one result on the output channel
// (out_valid_o/out_ready_i/out_data_o): read data, interrupt line and a
// bad-access flag for offsets outside the register map.
// The timer state commits at the accepting edge and the result sits in
// the output register from the next cycle on. Throughput is one
// transaction per cycle while the receiver does not stall; the path from
// the input payload through the register decode and counter update to
// the output register is a single pass of logic.
// When the receiver stalls, the result holds in the output register and
// in_ready_o drops until it is taken; a new transaction is accepted in the
// same cycle the held result leaves.
// Reset clears all counters, sets control to 0x3E0000 and the predivider
// to 0x7D, and empties the output register.
`default_nettype none

module arm_style_periodic_timer_unit #(
  parameter int unsigned COUNTER_WIDTH = 32,
  parameter int unsigned PREDIV_WIDTH  = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire apt_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output apt_pkg::out_t      out_data_o
);

  logic          accept;
  logic          out_valid_q, out_valid_d;
  apt_pkg::out_t out_data_q;
  apt_pkg::out_t res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  apt_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH),
    .PREDIV_WIDTH (PREDIV_WIDTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (accept),
    .in_i  (in_data_i),
    .res_o (res)
  );

  // Hold the result until the receiver takes it
  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
